// File: src/ssft_pkg.sv
// Shared types, widths and constants for the saturated state-feedback torque block
`timescale 1ns / 1ps

package ssft_pkg;

  // Item and field widths
  localparam int ELEM_W   = 32;
  localparam int ELEMS    = 12;
  localparam int IN_W     = ELEM_W * ELEMS;
  localparam int TORQUE_W = 22;
  localparam int OUT_W    = 4 * TORQUE_W;
  localparam int GAIN_W   = 32;
  localparam int LANES    = 5;

  // Feature is ten times its value, Q16.16; 38 bits hold every sum of the geometry rows
  localparam int FEAT_W   = 38;
  localparam int FLO_W    = 19;
  localparam int FHI_W    = FEAT_W - FLO_W;
  localparam int PLO_W    = GAIN_W + FLO_W + 1;
  localparam int PHI_W    = GAIN_W + FHI_W;
  localparam int PROD_W   = GAIN_W + FEAT_W;
  localparam int PAIR_W   = PROD_W + 1;
  localparam int QUAD_W   = PROD_W + 2;
  localparam int SUM_W    = PROD_W + 3;

  // Clip window: anything at or beyond it rounds to at least the torque limit
  localparam int CLIP_W   = 41;
  localparam int MAG_W    = CLIP_W - 1;
  localparam int QIN_W    = 24;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 27;
  localparam int QOUT_W   = 21;

  localparam logic signed [CLIP_W-1:0] CLIP_MAX = CLIP_W'(64'sd858994114560);
  localparam logic signed [CLIP_W-1:0] CLIP_MIN = CLIP_W'(-64'sd858994114560);
  localparam logic [MAG_W-1:0]         ROUND_HALF = MAG_W'(327680);
  localparam logic [RECIP_W-1:0]       RECIP_TEN  = RECIP_W'(13421773);
  localparam logic [QOUT_W-1:0]        TORQUE_LIM = QOUT_W'(1310720);
  localparam logic signed [ELEM_W:0]   HALF_PI_Q16 = 33'sd102944;

  // Configuration register indexes
  localparam int IDX_W = 3;
  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_A = 3'd0,
    REG_GAIN_B = 3'd1,
    REG_GAIN_C = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_GAIN_E = 3'd4
  } reg_idx_t;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET [LANES] = '{
    -32'sd47173665,
    -32'sd3008673,
    -32'sd35498295,
    32'sd64237339,
    -32'sd128349635
  };

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Load enables for the two lane stages
  typedef struct packed {
    logic mul_load;
    logic sum_load;
  } lane_ctl_t;

  // Load enables for the merge stages
  typedef struct packed {
    logic pair_load;
    logic quad_load;
    logic total_load;
    logic clip_load;
    logic round_load;
    logic div_load;
    logic out_load;
  } merge_ctl_t;

endpackage

// File: src/ssft_feature.sv
// Geometry rows: forms the five feedback features from one state item
`timescale 1ns / 1ps

module ssft_feature (
  input  logic                     clk,
  input  logic                     load,
  input  logic [ssft_pkg::IN_W-1:0] state,
  output ssft_pkg::feat_t          feat [ssft_pkg::LANES]
);

  logic signed [ssft_pkg::ELEM_W-1:0] ang [6];
  logic signed [ssft_pkg::ELEM_W-1:0] rte [6];
  logic signed [ssft_pkg::ELEM_W:0]   a4_dev;
  ssft_pkg::feat_t                    feat_next [ssft_pkg::LANES];

  // Unpack angles and rates
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ang[k] = state[k*ssft_pkg::ELEM_W +: ssft_pkg::ELEM_W];
      rte[k] = state[(k+6)*ssft_pkg::ELEM_W +: ssft_pkg::ELEM_W];
    end
  end

  // Remove the equilibrium of angle 4
  assign a4_dev = 33'(ang[4]) - ssft_pkg::HALF_PI_Q16;

  // Weighted sums at ten times scale
  always_comb begin
    feat_next[0] = -((ssft_pkg::FEAT_W'(ang[0]) * 38'sd12) +
                     (ssft_pkg::FEAT_W'(ang[1]) * 38'sd11) +
                     (ssft_pkg::FEAT_W'(ang[2]) * 38'sd11) +
                     ssft_pkg::FEAT_W'(a4_dev));
    feat_next[1] = -((ssft_pkg::FEAT_W'(rte[0]) * 38'sd12) +
                     (ssft_pkg::FEAT_W'(rte[1]) * 38'sd11) +
                     (ssft_pkg::FEAT_W'(rte[2]) * 38'sd11) +
                     ssft_pkg::FEAT_W'(rte[4]));
    feat_next[2] = ssft_pkg::FEAT_W'(ang[3]) * 38'sd10;
    feat_next[3] = ssft_pkg::FEAT_W'(rte[3]) * 38'sd10;
    feat_next[4] = (ssft_pkg::FEAT_W'(ang[0]) + ssft_pkg::FEAT_W'(ang[1])) * 38'sd10;
  end

  // Hold features for the lanes
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < ssft_pkg::LANES; k++) begin
        feat[k] <= feat_next[k];
      end
    end
  end

endmodule

// File: src/ssft_lane.sv
// One multiply lane: exact gain times feature product from two half products
`timescale 1ns / 1ps

module ssft_lane (
  input  logic                clk,
  input  ssft_pkg::lane_ctl_t ctl,
  input  ssft_pkg::gain_t     gain,
  input  ssft_pkg::feat_t     feat,
  output ssft_pkg::prod_t     prod
);

  logic signed [ssft_pkg::PLO_W-1:0] part_lo;
  logic signed [ssft_pkg::PHI_W-1:0] part_hi;
  logic signed [ssft_pkg::FLO_W:0]   feat_lo;
  logic signed [ssft_pkg::FHI_W-1:0] feat_hi;

  // Split the feature: unsigned low half, signed high half
  assign feat_lo = $signed({1'b0, feat[ssft_pkg::FLO_W-1:0]});
  assign feat_hi = feat[ssft_pkg::FEAT_W-1:ssft_pkg::FLO_W];

  // Multiply both halves
  always_ff @(posedge clk) begin
    if (ctl.mul_load) begin
      part_lo <= ssft_pkg::PLO_W'(gain * feat_lo);
      part_hi <= ssft_pkg::PHI_W'(gain * feat_hi);
    end
  end

  // Recombine the halves into the full product
  always_ff @(posedge clk) begin
    if (ctl.sum_load) begin
      prod <= (ssft_pkg::PROD_W'(part_hi) <<< ssft_pkg::FLO_W) + ssft_pkg::PROD_W'(part_lo);
    end
  end

endmodule

// File: src/ssft_merge.sv
// Merge: sums the lane products, rounds to Q16.16, clamps and forms the torques
`timescale 1ns / 1ps

module ssft_merge (
  input  logic                                 clk,
  input  ssft_pkg::merge_ctl_t                 ctl,
  input  ssft_pkg::prod_t                      prod [ssft_pkg::LANES],
  output logic signed [ssft_pkg::TORQUE_W-1:0] torque_neg,
  output logic signed [ssft_pkg::TORQUE_W-1:0] torque_pos
);

  logic signed [ssft_pkg::PAIR_W-1:0] pair_a, pair_b;
  logic signed [ssft_pkg::PROD_W-1:0] tail_a, tail_b;
  logic signed [ssft_pkg::QUAD_W-1:0] quad;
  logic signed [ssft_pkg::SUM_W-1:0]  total;
  logic signed [ssft_pkg::CLIP_W-1:0] clip, clip_next;
  logic [ssft_pkg::MAG_W-1:0]         mag;
  logic [ssft_pkg::QIN_W-1:0]         quo_in;
  logic                               neg_r, neg_d;
  logic [ssft_pkg::QIN_W+ssft_pkg::RECIP_W-1:0] recip_prod;
  logic [ssft_pkg::QOUT_W-1:0]        quo, quo_sat;
  logic signed [ssft_pkg::TORQUE_W-1:0] s_val;

  // Add pairs of lanes, carry the odd lane along
  always_ff @(posedge clk) begin
    if (ctl.pair_load) begin
      pair_a <= ssft_pkg::PAIR_W'(prod[0]) + ssft_pkg::PAIR_W'(prod[1]);
      pair_b <= ssft_pkg::PAIR_W'(prod[2]) + ssft_pkg::PAIR_W'(prod[3]);
      tail_a <= prod[4];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.quad_load) begin
      quad   <= ssft_pkg::QUAD_W'(pair_a) + ssft_pkg::QUAD_W'(pair_b);
      tail_b <= tail_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.total_load) begin
      total <= ssft_pkg::SUM_W'(quad) + ssft_pkg::SUM_W'(tail_b);
    end
  end

  // Clip the exact sum to the window that still rounds inside the limit
  always_comb begin
    if (total > ssft_pkg::SUM_W'(ssft_pkg::CLIP_MAX)) begin
      clip_next = ssft_pkg::CLIP_MAX;
    end else if (total < ssft_pkg::SUM_W'(ssft_pkg::CLIP_MIN)) begin
      clip_next = ssft_pkg::CLIP_MIN;
    end else begin
      clip_next = total[ssft_pkg::CLIP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clip_load) begin
      clip <= clip_next;
    end
  end

  // Round half away from zero on the magnitude, drop the 2^16 part
  assign mag = clip[ssft_pkg::CLIP_W-1] ? ssft_pkg::MAG_W'(-clip) : ssft_pkg::MAG_W'(clip);

  always_ff @(posedge clk) begin
    if (ctl.round_load) begin
      quo_in <= ssft_pkg::QIN_W'((mag + ssft_pkg::ROUND_HALF) >> 16);
      neg_r  <= clip[ssft_pkg::CLIP_W-1];
    end
  end

  // Divide by ten through the reciprocal
  assign recip_prod = ssft_pkg::QIN_W'(quo_in) * ssft_pkg::RECIP_TEN;

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      quo   <= ssft_pkg::QOUT_W'(recip_prod >> ssft_pkg::RECIP_SH);
      neg_d <= neg_r;
    end
  end

  // Clamp to the torque limit and apply the sign
  assign quo_sat = (quo > ssft_pkg::TORQUE_LIM) ? ssft_pkg::TORQUE_LIM : quo;
  assign s_val   = neg_d ? -$signed(ssft_pkg::TORQUE_W'(quo_sat))
                         : $signed(ssft_pkg::TORQUE_W'(quo_sat));

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      torque_pos <= s_val;
      torque_neg <= -s_val;
    end
  end

endmodule

// File: src/saturated_state_feedback_torque.sv
// Top level: gain registers, lane array, merge and the stream handshake
//
//  channel   direction  payload (lowest bits first)
//  s_*       in         angle_0..angle_5, rate_0..rate_5, 32 bits each
//  m_*       out        torque_0..torque_3, 22 bits each
//  cfg_*     in         gain write: index 0..4 = gain_a..gain_e
//
// One item per cycle sustained while m_tready is high; each item passes ten register
// stages (feature row, two multiply stages, three adder stages, clip, round,
// reciprocal divide, clamp) before it is offered on m_*.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse and input is taken while a result waits on m_tready if any stage is empty.
// Synchronous reset empties the pipeline and restores the gain reset values.
`timescale 1ns / 1ps

module saturated_state_feedback_torque (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // angle_0, angle_1, .. angle_5, rate_0, .. rate_5 (32 bits each)
  input  logic [ssft_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // torque_0, torque_1, torque_2, torque_3 (22 bits each)
  output logic [ssft_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_we,
  input  logic [ssft_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ssft_pkg::GAIN_W-1:0]   cfg_data
);

  localparam int NST = 10;

  ssft_pkg::gain_t      gain [ssft_pkg::LANES];
  ssft_pkg::feat_t      feat [ssft_pkg::LANES];
  ssft_pkg::prod_t      prod [ssft_pkg::LANES];
  ssft_pkg::lane_ctl_t  lane_ctl;
  ssft_pkg::merge_ctl_t merge_ctl;
  logic [NST-1:0]       vld;
  logic [NST:0]         rdy;
  logic signed [ssft_pkg::TORQUE_W-1:0] torque_neg, torque_pos;

  // Write gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ssft_pkg::LANES; k++) begin
        gain[k] <= ssft_pkg::GAIN_RESET[k];
      end
    end else if (cfg_we) begin
      case (cfg_index)
        ssft_pkg::REG_GAIN_A: gain[0] <= cfg_data;
        ssft_pkg::REG_GAIN_B: gain[1] <= cfg_data;
        ssft_pkg::REG_GAIN_C: gain[2] <= cfg_data;
        ssft_pkg::REG_GAIN_D: gain[3] <= cfg_data;
        ssft_pkg::REG_GAIN_E: gain[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ripple ready back from the output
  always_comb begin
    rdy[NST] = m_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NST-1];

  // Hand stage enables to the datapath
  assign lane_ctl.mul_load    = rdy[1];
  assign lane_ctl.sum_load    = rdy[2];
  assign merge_ctl.pair_load  = rdy[3];
  assign merge_ctl.quad_load  = rdy[4];
  assign merge_ctl.total_load = rdy[5];
  assign merge_ctl.clip_load  = rdy[6];
  assign merge_ctl.round_load = rdy[7];
  assign merge_ctl.div_load   = rdy[8];
  assign merge_ctl.out_load   = rdy[9];

  ssft_feature u_feature (
    .clk   (clk),
    .load  (rdy[0]),
    .state (s_tdata),
    .feat  (feat)
  );

  for (genvar g = 0; g < ssft_pkg::LANES; g++) begin : g_lane
    ssft_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .gain (gain[g]),
      .feat (feat[g]),
      .prod (prod[g])
    );
  end

  ssft_merge u_merge (
    .clk        (clk),
    .ctl        (merge_ctl),
    .prod       (prod),
    .torque_neg (torque_neg),
    .torque_pos (torque_pos)
  );

  assign m_tdata = {torque_pos, torque_pos, torque_neg, torque_neg};

`ifndef ASSERT_OFF
  // Drives 0/1 mirror drives 2/3
  a_mirror: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:0] == m_tdata[43:22]) && (m_tdata[65:44] == m_tdata[87:66])
                 && ($signed(m_tdata[21:0]) == -$signed(m_tdata[65:44])))
    else $error("torque drives not mirrored");

  // Output stays within the torque limit
  a_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[65:44]) <= 22'sd1310720)
                 && ($signed(m_tdata[65:44]) >= -22'sd1310720))
    else $error("torque beyond limit");

  // Input is refused only when every stage is full and the output is stalled
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (vld == {NST{1'b1}}) && !m_tready)
    else $error("input refused with room in the pipeline");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");
`endif

endmodule
